// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the bank mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock, muted while reset is high.
`define CBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bank mapper check failed");

// Concurrent check that also runs through reset.
`define CBM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bank mapper reset check failed");

`endif

// ===== sv/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and codes of the cartridge bank mapper
// Field widths, controller, access and target codes, register indexes and
// the bank state carried between the bank register file and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

   // field widths
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int TARGET_W   = 2;
   localparam int ROM_LOC_W  = 23;
   localparam int RAM_LOC_W  = 17;
   localparam int ROM_BANK_W = 9;
   localparam int RAM_BANK_W = 4;
   localparam int CTRL_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   // controller types (codes 6 and 7 behave as none)
   localparam logic [CTRL_W-1:0] CTRL_NONE     = 3'd0;
   localparam logic [CTRL_W-1:0] CTRL_MBC1_16_8 = 3'd1;
   localparam logic [CTRL_W-1:0] CTRL_MBC1_4_32 = 3'd2;
   localparam logic [CTRL_W-1:0] CTRL_MBC2     = 3'd3;
   localparam logic [CTRL_W-1:0] CTRL_MBC3     = 3'd4;
   localparam logic [CTRL_W-1:0] CTRL_MBC5     = 3'd5;

   // access kinds
   localparam logic [MODE_W-1:0] MODE_ROM_READ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONTROL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RAM_READ  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RAM_WRITE = 2'd3;

   // memory targets
   localparam logic [TARGET_W-1:0] TARGET_NONE = 2'd0;
   localparam logic [TARGET_W-1:0] TARGET_ROM  = 2'd1;
   localparam logic [TARGET_W-1:0] TARGET_RAM  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROLLER_TYPE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_PRESENT     = 1'd1;

   // reset values of the bank registers
   localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 9'd1;
   localparam logic [RAM_BANK_W-1:0] RAM_BANK_RESET = 4'd0;

   typedef struct packed {
      logic [ROM_BANK_W-1:0] rom_page;
      logic [RAM_BANK_W-1:0] ram_page;
   } bank_state_type;

endpackage

`default_nettype wire

// ===== sv/cbm_req_if.sv =====
// ----------------------------------------------------------------------------
// cbm_req_if: bus access request channel
// Valid/ready channel carrying one CPU bus access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [cbm_pkg::MODE_W-1:0]  mode;
   logic [cbm_pkg::ADDR_W-1:0]  bus_address;
   logic [cbm_pkg::DATA_W-1:0]  bus_data;

   modport source (output valid, output mode, output bus_address, output bus_data,
                   input ready);
   modport sink   (input valid, input mode, input bus_address, input bus_data,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/cbm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cbm_rsp_if: mapped access result channel
// Valid/ready channel carrying the physical address, write control and banks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cbm_pkg::TARGET_W-1:0]    target;
   logic [cbm_pkg::ROM_LOC_W-1:0]   rom_location;
   logic [cbm_pkg::RAM_LOC_W-1:0]   ram_location;
   logic                            ram_write_enable;
   logic [cbm_pkg::DATA_W-1:0]      ram_write_byte;
   logic [cbm_pkg::ROM_BANK_W-1:0]  current_rom_bank;
   logic [cbm_pkg::RAM_BANK_W-1:0]  current_ram_bank;

   modport source (output valid, output target, output rom_location,
                   output ram_location, output ram_write_enable,
                   output ram_write_byte, output current_rom_bank,
                   output current_ram_bank, input ready);
   modport sink   (input valid, input target, input rom_location,
                   input ram_location, input ram_write_enable,
                   input ram_write_byte, input current_rom_bank,
                   input current_ram_bank, output ready);
endinterface

`default_nettype wire

// ===== sv/cbm_bank_regs.sv =====
// ----------------------------------------------------------------------------
// cbm_bank_regs: ROM and RAM bank registers
// Decodes control writes per controller type and holds the bank state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_bank_regs (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         update_en,
   input  wire logic [cbm_pkg::CTRL_W-1:0]   ctrl_type,
   input  wire logic [cbm_pkg::ADDR_W-1:0]   bus_address,
   input  wire logic [cbm_pkg::DATA_W-1:0]   bus_data,
   output cbm_pkg::bank_state_type           banks_now,
   output cbm_pkg::bank_state_type           banks_next
);
   import cbm_pkg::*;

   bank_state_type banks_ff;
   bank_state_type banks_in;

   logic       low_sel;
   logic       high_sel;
   logic       mbc5_low_sel;
   logic       mbc5_high_sel;
   logic [4:0] mbc1_low;
   logic [3:0] mbc2_low;
   logic [6:0] mbc3_low;

   // decode the control write windows
   assign low_sel       = (bus_address[15:13] == 3'b001);
   assign high_sel      = (bus_address[15:13] == 3'b010);
   assign mbc5_low_sel  = (bus_address[15:12] == 4'h2);
   assign mbc5_high_sel = (bus_address[15:12] == 4'h3);

   // masked bank numbers, with bank zero mapped to bank one
   assign mbc1_low = (bus_data[4:0] == 5'd0) ? 5'd1 : bus_data[4:0];
   assign mbc2_low = (bus_data[3:0] == 4'd0) ? 4'd1 : bus_data[3:0];
   assign mbc3_low = (bus_data[6:0] == 7'd0) ? 7'd1 : bus_data[6:0];

   // next bank state for a control write
   always_comb begin
      banks_in = banks_ff;
      if (update_en) begin
         case (ctrl_type)
            CTRL_MBC1_16_8, CTRL_MBC1_4_32: begin
               if (low_sel) begin
                  banks_in.rom_page = {1'b0, banks_ff.rom_page[7:5], mbc1_low};
               end
               if (high_sel) begin
                  if (ctrl_type == CTRL_MBC1_16_8) begin
                     banks_in.rom_page = {2'b00, bus_data[1:0], banks_ff.rom_page[4:0]};
                  end else begin
                     banks_in.ram_page = bus_data[3:0];
                  end
               end
            end
            CTRL_MBC2: begin
               if (low_sel) begin
                  banks_in.rom_page = {5'd0, mbc2_low};
               end
            end
            CTRL_MBC3: begin
               if (low_sel) begin
                  banks_in.rom_page = {2'b00, mbc3_low};
               end
               if (high_sel) begin
                  banks_in.ram_page = bus_data[3:0];
               end
            end
            CTRL_MBC5: begin
               if (mbc5_low_sel) begin
                  banks_in.rom_page = {banks_ff.rom_page[8], bus_data};
               end
               if (mbc5_high_sel) begin
                  banks_in.rom_page = {bus_data[0], banks_ff.rom_page[7:0]};
               end
               if (high_sel) begin
                  banks_in.ram_page = bus_data[3:0];
               end
            end
            default: begin
               banks_in = banks_ff;
            end
         endcase
      end
   end

   // hold the bank registers
   always_ff @(posedge clock) begin
      if (reset) begin
         banks_ff.rom_page <= ROM_BANK_RESET;
         banks_ff.ram_page <= RAM_BANK_RESET;
      end else begin
         banks_ff <= banks_in;
      end
   end

   assign banks_now  = banks_ff;
   assign banks_next = banks_in;

endmodule

`default_nettype wire

// ===== sv/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: cartridge memory bank controller address mapper
// Maps CPU bus accesses to physical ROM and RAM addresses through bank
// registers that control writes update per controller type.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one bus access per request (mode, bus_address, bus_data);
//   rsp_ch returns exactly one result per request, in order.
//   csr_* writes the controller type (index 0) and RAM presence (index 1);
//   write them only while no request is in flight.
// Timing: a request accepted at a clock edge shows its result on rsp_ch
//   from the next cycle on. Bank update and address mapping are
//   combinational, between the request and the result register.
// Throughput: one request per cycle, sustained, as long as rsp_ch takes
//   results; the result register is the only stage.
// Stall: while a result waits and rsp_ch.ready is low, req_ch.ready drops
//   and the result holds; the cycle rsp_ch.ready rises, a new request is
//   taken in the same cycle the waiting result leaves.
// Reset: synchronous, active high. Clears the result valid, sets the ROM
//   bank to 1, the RAM bank to 0, controller type none and RAM present.
//   No request is taken while reset is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cbm_req_if.sink                             req_ch,
   cbm_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_write_enable,
   input  wire logic [cbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cbm_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import cbm_pkg::*;

   logic [CTRL_W-1:0]  ctrl_type_ff;
   logic               ram_present_ff;

   logic               req_fire;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   bank_state_type     banks_now;
   bank_state_type     banks_next;

   logic [TARGET_W-1:0]  target_in,  target_ff;
   logic [ROM_LOC_W-1:0] rom_loc_in, rom_loc_ff;
   logic [RAM_LOC_W-1:0] ram_loc_in, ram_loc_ff;
   logic                 we_in,      we_ff;
   logic [DATA_W-1:0]    wbyte_in,   wbyte_ff;
   logic [ROM_BANK_W-1:0] rom_bank_ff;
   logic [RAM_BANK_W-1:0] ram_bank_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_type_ff   <= CTRL_NONE;
         ram_present_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CONTROLLER_TYPE: ctrl_type_ff   <= csr_write_data;
            CSR_RAM_PRESENT:     ram_present_ff <= csr_write_data[0];
            default:             ctrl_type_ff   <= ctrl_type_ff;
         endcase
      end
   end

   // take a request whenever the result register is free or draining
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;

   cbm_bank_regs u_bank_regs (
      .clock       (clock),
      .reset       (reset),
      .update_en   (req_fire && (req_ch.mode == MODE_CONTROL)),
      .ctrl_type   (ctrl_type_ff),
      .bus_address (req_ch.bus_address),
      .bus_data    (req_ch.bus_data),
      .banks_now   (banks_now),
      .banks_next  (banks_next)
   );

   // map the access through the current banks
   always_comb begin
      target_in  = TARGET_NONE;
      rom_loc_in = '0;
      ram_loc_in = '0;
      we_in      = 1'b0;
      wbyte_in   = '0;
      unique case (req_ch.mode)
         MODE_ROM_READ: begin
            target_in = TARGET_ROM;
            if (req_ch.bus_address[15:14] == 2'b01) begin
               rom_loc_in = {banks_now.rom_page, req_ch.bus_address[13:0]};
            end else begin
               rom_loc_in = {{(ROM_LOC_W-ADDR_W){1'b0}}, req_ch.bus_address};
            end
         end
         MODE_CONTROL: begin
            target_in = TARGET_NONE;
         end
         MODE_RAM_READ: begin
            target_in  = TARGET_RAM;
            ram_loc_in = {banks_now.ram_page, req_ch.bus_address[12:0]};
         end
         MODE_RAM_WRITE: begin
            ram_loc_in = {banks_now.ram_page, req_ch.bus_address[12:0]};
            if (ctrl_type_ff == CTRL_MBC2) begin
               // built-in RAM keeps the low nibble only
               target_in = TARGET_RAM;
               we_in     = 1'b1;
               wbyte_in  = {4'h0, req_ch.bus_data[3:0]};
            end else if (ram_present_ff) begin
               target_in = TARGET_RAM;
               we_in     = 1'b1;
               wbyte_in  = req_ch.bus_data;
            end else begin
               // drop the write when no RAM is fitted
               target_in = TARGET_NONE;
            end
         end
         default: begin
            target_in = TARGET_NONE;
         end
      endcase
   end

   // result valid: set on a request, cleared when the result is taken
   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         target_ff   <= target_in;
         rom_loc_ff  <= rom_loc_in;
         ram_loc_ff  <= ram_loc_in;
         we_ff       <= we_in;
         wbyte_ff    <= wbyte_in;
         rom_bank_ff <= banks_next.rom_page;
         ram_bank_ff <= banks_next.ram_page;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.target           = target_ff;
   assign rsp_ch.rom_location     = rom_loc_ff;
   assign rsp_ch.ram_location     = ram_loc_ff;
   assign rsp_ch.ram_write_enable = we_ff;
   assign rsp_ch.ram_write_byte   = wbyte_ff;
   assign rsp_ch.current_rom_bank = rom_bank_ff;
   assign rsp_ch.current_ram_bank = ram_bank_ff;

endmodule

`default_nettype wire

// ===== sv/cbm_checker.sv =====
// ----------------------------------------------------------------------------
// cbm_checker: port-level checks for the cartridge bank mapper
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cbm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [cbm_pkg::MODE_W-1:0]     req_mode,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [cbm_pkg::TARGET_W-1:0]   rsp_target,
   input wire logic [cbm_pkg::ROM_LOC_W-1:0]  rsp_rom_location,
   input wire logic [cbm_pkg::RAM_LOC_W-1:0]  rsp_ram_location,
   input wire logic                           rsp_write_enable
);
   import cbm_pkg::*;

   // a waiting result stays until taken
   `CBM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // a control write yields an empty result in the next cycle
   `CBM_ASSERT(a_ctrl_empty, clock, reset, req_valid && req_ready && req_mode == MODE_CONTROL |=> rsp_valid && rsp_target == TARGET_NONE && rsp_rom_location == '0 && rsp_ram_location == '0 && !rsp_write_enable)

   // a ROM read targets the ROM and leaves the RAM address clear
   `CBM_ASSERT(a_rom_read, clock, reset, req_valid && req_ready && req_mode == MODE_ROM_READ |=> rsp_valid && rsp_target == TARGET_ROM && rsp_ram_location == '0)

   // a RAM write strobe always comes with the RAM target
   `CBM_ASSERT(a_we_target, clock, reset, rsp_valid && rsp_write_enable |-> rsp_target == TARGET_RAM && rsp_rom_location == '0)

   // reset empties the result register
   `CBM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_mode         (req_ch.mode),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_target       (rsp_ch.target),
   .rsp_rom_location (rsp_ch.rom_location),
   .rsp_ram_location (rsp_ch.ram_location),
   .rsp_write_enable (rsp_ch.ram_write_enable)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cartridge_bank_mapper
// Sends bus access requests under every controller type, with and without
// cartridge RAM, keeps its own copy of the bank registers and checks every
// mapped result in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;
   import cbm_pkg::*;

   // controller code outside the named set, treated as no controller
   localparam logic [CTRL_W-1:0] CTRL_SPARE_7 = 3'd7;

   localparam int MAX_WAIT        = 13;
   localparam int RANDOM_ACCESSES = 1600;
   localparam int PHASE_LEN       = 100;
   localparam int CALM_LEN        = 40;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic [TARGET_W-1:0]   target;
      logic [ROM_LOC_W-1:0]  rom_location;
      logic [RAM_LOC_W-1:0]  ram_location;
      logic                  write_enable;
      logic [DATA_W-1:0]     write_byte;
      logic [ROM_BANK_W-1:0] rom_page;
      logic [RAM_BANK_W-1:0] ram_page;
   } mapping_t;

   // Bank register tracker: predicts each mapping and checks results in order
   class mapping_predictor;
      logic [CTRL_W-1:0]     ctrl;
      logic                  ram_present;
      logic [ROM_BANK_W-1:0] rom_page;
      logic [RAM_BANK_W-1:0] ram_page;
      mapping_t              due_mappings[$];
      int                    failures;
      int                    accesses;
      int                    control_writes;
      int                    ram_writes;
      int                    settings;

      function new();
         ctrl           = CTRL_NONE;
         ram_present    = 1'b1;
         rom_page       = ROM_BANK_RESET;
         ram_page       = RAM_BANK_RESET;
         failures       = 0;
         accesses       = 0;
         control_writes = 0;
         ram_writes     = 0;
         settings       = 0;
      endfunction

      function void set_mapping(logic [CTRL_W-1:0] c, logic r);
         ctrl        = c;
         ram_present = r;
         settings++;
      endfunction

      // Apply a control write to the bank registers
      function void bank_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
         logic low_sel;
         logic high_sel;
         low_sel  = (a >= 16'h2000) && (a <= 16'h3FFF);
         high_sel = (a >= 16'h4000) && (a <= 16'h5FFF);
         case (ctrl)
            CTRL_MBC1_16_8, CTRL_MBC1_4_32: begin
               // low five bits with zero fix; the top bit drops out
               if (low_sel)
                  rom_page = {1'b0, rom_page[7:5], (d[4:0] == 5'd0) ? 5'd1 : d[4:0]};
               if (high_sel) begin
                  if (ctrl == CTRL_MBC1_16_8)
                     rom_page = {2'b00, d[1:0], rom_page[4:0]};
                  else
                     ram_page = d[3:0];
               end
            end
            CTRL_MBC2: begin
               if (low_sel)
                  rom_page = {5'd0, (d[3:0] == 4'd0) ? 4'd1 : d[3:0]};
            end
            CTRL_MBC3: begin
               if (low_sel)
                  rom_page = {2'b00, (d[6:0] == 7'd0) ? 7'd1 : d[6:0]};
               if (high_sel)
                  ram_page = d[3:0];
            end
            CTRL_MBC5: begin
               // no zero fix here
               if ((a >= 16'h2000) && (a <= 16'h2FFF))
                  rom_page[7:0] = d;
               if ((a >= 16'h3000) && (a <= 16'h3FFF))
                  rom_page[8] = d[0];
               if (high_sel)
                  ram_page = d[3:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Work out the mapping of one accepted request and queue it
      function void note_request(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                 logic [DATA_W-1:0] d);
         mapping_t r;
         r = '0;
         accesses++;
         case (m)
            MODE_ROM_READ: begin
               r.target = TARGET_ROM;
               if ((a >= 16'h4000) && (a <= 16'h7FFF))
                  r.rom_location = {rom_page, a[13:0]};
               else
                  r.rom_location = {7'd0, a};
            end
            MODE_CONTROL: begin
               control_writes++;
               bank_write(a, d);
            end
            default: begin
               r.target       = TARGET_RAM;
               r.ram_location = {ram_page, a[12:0]};
               if (m == MODE_RAM_WRITE) begin
                  ram_writes++;
                  if (ctrl == CTRL_MBC2) begin
                     r.write_enable = 1'b1;
                     r.write_byte   = {4'd0, d[3:0]};
                  end else if (ram_present) begin
                     r.write_enable = 1'b1;
                     r.write_byte   = d;
                  end else begin
                     // suppressed write still shows the mapped address
                     r.target = TARGET_NONE;
                  end
               end
            end
         endcase
         r.rom_page = rom_page;
         r.ram_page = ram_page;
         due_mappings.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] want_v, logic [31:0] seen_v);
         if (want_v !== seen_v) begin
            failures++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want_v, seen_v);
         end
      endfunction

      // Check one accepted result against the oldest prediction
      function void check_result(mapping_t seen);
         mapping_t want;
         if (due_mappings.size() == 0) begin
            failures++;
            $error("result arrived with no request outstanding");
            return;
         end
         want = due_mappings.pop_front();
         compare("target", 32'(want.target), 32'(seen.target));
         compare("rom_location", 32'(want.rom_location), 32'(seen.rom_location));
         compare("ram_location", 32'(want.ram_location), 32'(seen.ram_location));
         compare("ram_write_enable", 32'(want.write_enable), 32'(seen.write_enable));
         compare("ram_write_byte", 32'(want.write_byte), 32'(seen.write_byte));
         compare("current_rom_bank", 32'(want.rom_page), 32'(seen.rom_page));
         compare("current_ram_bank", 32'(want.ram_page), 32'(seen.ram_page));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int unsigned cycle_count = 0;
   mapping_t seen_result;
   mapping_predictor mapper = new();

   cbm_req_if req_ch();
   cbm_rsp_if rsp_ch();

   cartridge_bank_mapper u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Watch both handshakes; the result leaving now belongs to an older request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_result.target       = rsp_ch.target;
            seen_result.rom_location = rsp_ch.rom_location;
            seen_result.ram_location = rsp_ch.ram_location;
            seen_result.write_enable = rsp_ch.ram_write_enable;
            seen_result.write_byte   = rsp_ch.ram_write_byte;
            seen_result.rom_page     = rsp_ch.current_rom_bank;
            seen_result.ram_page     = rsp_ch.current_ram_bank;
            mapper.check_result(seen_result);
         end
         if (req_ch.valid && req_ch.ready)
            mapper.note_request(req_ch.mode, req_ch.bus_address, req_ch.bus_data);
      end
   end

   // Result side: stall a random number of cycles before taking each result
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Send one request after a random gap and hold it until taken
   task automatic send_access(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= m;
      req_ch.bus_address <= a;
      req_ch.bus_data    <= d;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   // Drop valid and wait until every result is back and the block is quiet
   task automatic drain_requests();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (mapper.due_mappings.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Write both configuration registers back to back
   task automatic set_mapping(input logic [CTRL_W-1:0] c, input logic r);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CONTROLLER_TYPE;
      csr_write_data   <= c;
      @(posedge clock);
      csr_index        <= CSR_RAM_PRESENT;
      csr_write_data   <= {2'b00, r};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mapper.set_mapping(c, r);
   endtask

   // Draw a request, mostly inside the windows that the mapper decodes
   function automatic void draw_access(output logic [MODE_W-1:0] m,
                                       output logic [ADDR_W-1:0] a,
                                       output logic [DATA_W-1:0] d);
      int pick;
      m    = MODE_W'($urandom_range(0, 3));
      d    = DATA_W'($urandom);
      pick = $urandom_range(0, 9);
      case (m)
         MODE_CONTROL: begin
            a = (pick < 8) ? ADDR_W'($urandom_range(16'h2000, 16'h5FFF))
                           : ADDR_W'($urandom);
         end
         MODE_ROM_READ: begin
            a = (pick < 7) ? ADDR_W'($urandom_range(16'h4000, 16'h7FFF))
                           : ADDR_W'($urandom);
         end
         default: begin
            a = (pick < 8) ? ADDR_W'($urandom_range(16'hA000, 16'hBFFF))
                           : ADDR_W'($urandom);
         end
      endcase
      // clear the low bank bits now and then to hit the zero fix
      pick = $urandom_range(0, 7);
      if (pick == 0)
         d = d & 8'hE0;
      else if (pick == 1)
         d = d & 8'h80;
   endfunction

   initial begin : stimulus
      logic [MODE_W-1:0] m;
      logic [ADDR_W-1:0] a;
      logic [DATA_W-1:0] d;
      int phase;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_ROM_READ;
      req_ch.bus_address = '0;
      req_ch.bus_data    = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_CONTROLLER_TYPE;
      csr_write_data     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no controller after reset: pass-through reads, ignored bank writes
      send_access(MODE_ROM_READ, 16'h0000, 8'h00);
      send_access(MODE_ROM_READ, 16'h4000, 8'hFF);
      send_access(MODE_ROM_READ, 16'hFFFF, 8'h00);
      send_access(MODE_CONTROL, 16'h2000, 8'h05);
      send_access(MODE_RAM_READ, 16'hA000, 8'h00);
      send_access(MODE_RAM_WRITE, 16'hBFFF, 8'hFF);
      send_access(MODE_RAM_READ, 16'h0000, 8'h00);
      drain_requests();

      // mbc1 16/8: zero fix on masked bits, upper bits, writes elsewhere
      set_mapping(CTRL_MBC1_16_8, 1'b1);
      send_access(MODE_CONTROL, 16'h2000, 8'h20);
      send_access(MODE_CONTROL, 16'h4000, 8'hFF);
      send_access(MODE_CONTROL, 16'h3FFF, 8'h1F);
      send_access(MODE_ROM_READ, 16'h7FFF, 8'h00);
      send_access(MODE_CONTROL, 16'h8000, 8'h07);
      send_access(MODE_RAM_WRITE, 16'hA123, 8'hA5);
      drain_requests();

      // mbc2 without RAM: nibble writes still go through
      set_mapping(CTRL_MBC2, 1'b0);
      send_access(MODE_CONTROL, 16'h2100, 8'hF0);
      send_access(MODE_RAM_WRITE, 16'hA000, 8'hFF);
      send_access(MODE_CONTROL, 16'h3000, 8'h0A);
      drain_requests();

      // mbc5 without RAM: bank 0, ninth bank bit, suppressed write
      set_mapping(CTRL_MBC5, 1'b0);
      send_access(MODE_CONTROL, 16'h2000, 8'h00);
      send_access(MODE_CONTROL, 16'h3000, 8'hFF);
      send_access(MODE_CONTROL, 16'h5FFF, 8'hFF);
      send_access(MODE_ROM_READ, 16'h4000, 8'h00);
      send_access(MODE_RAM_WRITE, 16'hBFFF, 8'h3C);
      send_access(MODE_RAM_READ, 16'hFFFF, 8'h00);
      drain_requests();

      // spare controller code: bank writes ignored
      set_mapping(CTRL_SPARE_7, 1'b1);
      send_access(MODE_CONTROL, 16'h2000, 8'h11);
      send_access(MODE_ROM_READ, 16'h5555, 8'h00);
      drain_requests();

      // random phases, two per controller code, RAM absent in the second half
      for (int i = 0; i < RANDOM_ACCESSES; i++) begin
         if (i % PHASE_LEN == 0) begin
            phase = i / PHASE_LEN;
            drain_requests();
            set_mapping(CTRL_W'(phase % 8), 1'((phase / 8) % 2 == 0));
         end
         if (i % CALM_LEN == 0) begin
            req_calm = ($urandom_range(0, 3) == 0);
            rsp_calm = ($urandom_range(0, 3) == 0);
         end
         draw_access(m, a, d);
         send_access(m, a, d);
      end
      drain_requests();
      repeat (4) @(posedge clock);

      $display("Checked %0d accesses (%0d control writes, %0d RAM writes) across %0d settings",
               mapper.accesses, mapper.control_writes, mapper.ram_writes, mapper.settings);
      $display("Controller codes 0 to 7, RAM present and absent, random gaps and stalls");
      if (mapper.failures == 0 && mapper.due_mappings.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cbm_pkg.sv
sv/cbm_req_if.sv
sv/cbm_rsp_if.sv
sv/cbm_bank_regs.sv
sv/cartridge_bank_mapper.sv
sv/cbm_checker.sv
sim/tb.sv
